FILE: src/btb_pkg.sv
// Package: shared types and constants for the bbox tile binner.
package btb_pkg;
  localparam int unsigned MaxLodLevels = 8;
  localparam int unsigned MaxTileRefs  = 64;
  localparam logic [15:0] DefaultTileSize = 16'd4096;
  localparam int unsigned QDepth = 2;

  typedef enum logic {
    CFG_BASE_TILE_SIZE = 1'b0,
    CFG_MAX_REFS       = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]         lod;
    logic [15:0]        layer;
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [31:0] max_x;
    logic signed [31:0] max_y;
    logic               oversize;
  } job_t;
endpackage

FILE: src/btb_divider.sv
// Iterative floor divider: signed 32-bit value over a positive 23-bit divisor.
module btb_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] num_i,
  input  logic [22:0]        den_i,
  output logic               done_o,
  output logic signed [31:0] quot_o
);
  logic [31:0] mag_q, mag_d;
  logic [31:0] quo_q, quo_d;
  logic [22:0] rem_q, rem_d;
  logic [22:0] den_q, den_d;
  logic        neg_q, neg_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [23:0] trial;
  logic [23:0] diff;

  always_comb begin
    mag_d = mag_q; quo_d = quo_q; rem_d = rem_q; den_d = den_q;
    neg_d = neg_q; cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    trial = {rem_q, mag_q[31]};
    diff = trial - {1'b0, den_q};
    if (start_i) begin
      neg_d = num_i[31];
      mag_d = num_i[31] ? ~num_i : num_i;
      den_d = den_i; rem_d = '0; quo_d = '0; cnt_d = '0; busy_d = 1'b1;
    end else if (busy_q) begin
      mag_d = {mag_q[30:0], 1'b0};
      if (!diff[23]) begin
        rem_d = diff[22:0]; quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = trial[22:0]; quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  // floor(v/d) for v<0 is -(floor((-v-1)/d)) - 1 = ~q
  assign quot_o = neg_q ? ~quo_q : quo_q;
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d; quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d; neg_q <= neg_d;
  end
endmodule

FILE: src/btb_front.sv
// Front end: corner ordering, four floor divisions and the large-shape check.
module btb_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  logic [2:0]         lod_level_i,
  input  logic [15:0]        layer_id_i,
  input  logic signed [31:0] corner_a_x_i,
  input  logic signed [31:0] corner_a_y_i,
  input  logic signed [31:0] corner_b_x_i,
  input  logic signed [31:0] corner_b_y_i,
  input  logic [15:0]        base_tile_size_i,
  input  logic [6:0]         max_refs_i,
  output logic               job_valid_o,
  input  logic               job_ready_i,
  output btb_pkg::job_t      job_o
);
  typedef enum logic [2:0] {S_IDLE, S_DIV, S_CHECK, S_MUL, S_OUT} state_e;
  state_e state_q;
  logic [1:0] sel_q;
  logic signed [31:0] coord_q [4];
  logic signed [31:0] res_q [4];
  logic [2:0] lod_q;
  logic [15:0] layer_q;
  logic [22:0] size_q;
  logic [6:0] limit_q;
  logic large_q;
  logic [13:0] prod_q;
  logic go_q;
  logic div_done;
  logic signed [31:0] div_quot;
  logic [32:0] spx, spy;
  logic [15:0] base;
  logic [6:0] lim;

  assign base = (base_tile_size_i == '0) ? btb_pkg::DefaultTileSize : base_tile_size_i;
  assign lim = (max_refs_i == '0) ? 7'd1 :
               (max_refs_i > 7'(btb_pkg::MaxTileRefs)) ? 7'(btb_pkg::MaxTileRefs) : max_refs_i;
  assign full_o = (state_q != S_IDLE);

  btb_divider u_div (
    .clk_i, .rst_ni,
    .start_i(go_q),
    .num_i  (coord_q[sel_q]),
    .den_i  (size_q),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign spx = 33'(signed'({res_q[2][31], res_q[2]}) - signed'({res_q[0][31], res_q[0]}));
  assign spy = 33'(signed'({res_q[3][31], res_q[3]}) - signed'({res_q[1][31], res_q[1]}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; sel_q <= '0; go_q <= 1'b0;
    end else begin
      go_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (push_i && (32'(lod_level_i) < btb_pkg::MaxLodLevels)) begin
            state_q <= S_DIV; sel_q <= '0; go_q <= 1'b1;
          end
        end
        S_DIV: begin
          if (div_done) begin
            sel_q <= sel_q + 2'd1;
            if (sel_q == 2'd3) state_q <= S_CHECK;
            else go_q <= 1'b1;
          end
        end
        S_CHECK: state_q <= S_MUL;
        S_MUL: state_q <= S_OUT;
        S_OUT: if (job_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && push_i) begin
      coord_q[0] <= (corner_a_x_i < corner_b_x_i) ? corner_a_x_i : corner_b_x_i;
      coord_q[1] <= (corner_a_y_i < corner_b_y_i) ? corner_a_y_i : corner_b_y_i;
      coord_q[2] <= (corner_a_x_i < corner_b_x_i) ? corner_b_x_i : corner_a_x_i;
      coord_q[3] <= (corner_a_y_i < corner_b_y_i) ? corner_b_y_i : corner_a_y_i;
      lod_q <= lod_level_i; layer_q <= layer_id_i;
      size_q <= 23'({7'd0, base} << lod_level_i);
      limit_q <= lim;
    end
    if (state_q == S_DIV && div_done) res_q[sel_q] <= div_quot;
    if (state_q == S_CHECK) begin
      large_q <= (spx >= 33'(limit_q)) || (spy >= 33'(limit_q));
      prod_q <= {7'd0, spx[6:0] + 7'd1} * {7'd0, spy[6:0] + 7'd1};
    end
    if (state_q == S_MUL) large_q <= large_q || (prod_q > 14'(limit_q));
  end

  assign job_valid_o = (state_q == S_OUT);
  always_comb begin
    job_o.lod = lod_q; job_o.layer = layer_q;
    job_o.min_x = res_q[0]; job_o.min_y = res_q[1];
    job_o.max_x = res_q[2]; job_o.max_y = res_q[3];
    job_o.oversize = large_q;
  end
endmodule

FILE: src/btb_back.sv
// Back end: job queue and key walker, column outer and row inner.
module btb_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  output logic               job_ready_o,
  input  btb_pkg::job_t      job_i,
  output logic               empty_o,
  input  logic               pop_i,
  output logic [2:0]         key_lod_o,
  output logic [15:0]        key_layer_o,
  output logic signed [31:0] tile_col_o,
  output logic signed [31:0] tile_row_o,
  output logic               large_shape_o,
  output logic               last_key_o
);
  btb_pkg::job_t q_q [btb_pkg::QDepth];
  logic [1:0] cnt_q;
  logic wp_q, rp_q;
  logic act_q;
  btb_pkg::job_t cur_q;
  logic signed [31:0] x_q, y_q;
  logic last;
  logic take;

  assign job_ready_o = (cnt_q != 2'(btb_pkg::QDepth));
  assign take = !act_q && (cnt_q != 2'd0);
  assign last = cur_q.oversize || ((x_q == cur_q.max_x) && (y_q == cur_q.max_y));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; wp_q <= 1'b0; rp_q <= 1'b0; act_q <= 1'b0;
    end else begin
      cnt_q <= cnt_q + 2'(job_valid_i && job_ready_o) - 2'(take);
      if (job_valid_i && job_ready_o) wp_q <= ~wp_q;
      if (take) begin
        rp_q <= ~rp_q; act_q <= 1'b1;
      end else if (act_q && pop_i && last) act_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_valid_i && job_ready_o) q_q[wp_q] <= job_i;
    if (take) begin
      cur_q <= q_q[rp_q]; x_q <= q_q[rp_q].min_x; y_q <= q_q[rp_q].min_y;
    end else if (act_q && pop_i && !last) begin
      if (y_q == cur_q.max_y) begin
        y_q <= cur_q.min_y; x_q <= x_q + 32'sd1;
      end else y_q <= y_q + 32'sd1;
    end
  end

  assign empty_o = !act_q;
  assign key_lod_o = cur_q.lod;
  assign key_layer_o = cur_q.layer;
  assign tile_col_o = x_q;
  assign tile_row_o = y_q;
  assign large_shape_o = cur_q.oversize;
  assign last_key_o = last;

  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(btb_pkg::QDepth)) else $error("queue overflow");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act_q && !pop_i) |=> ($stable(x_q) && $stable(y_q))) else $error("key moved");
  a_large: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act_q && cur_q.oversize) |-> last) else $error("large not last");
endmodule

FILE: src/bbox_tile_binner_core.sv
// Top level: bbox tile binner, config registers, front and back ends.
// channel | direction | handshake
// input   | in        | push_i / full_o
// result  | out       | pop_i / empty_o
// config  | in        | cfg_valid_i / cfg_ready_o
// In the front end an item passes from accept to job handoff through four serial
// divisions, then the check, multiply and handoff states.
// The back end loads a queued job when idle, then gives one key per cycle while pop_i is high.
// Full stays high from accept until the job enters the two-entry queue, so no new item
// is accepted before then; a full queue stalls the front end. Reset clears control state.
module bbox_tile_binner_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  logic [2:0]         lod_level_i,
  input  logic [15:0]        layer_id_i,
  input  logic signed [31:0] corner_a_x_i,
  input  logic signed [31:0] corner_a_y_i,
  input  logic signed [31:0] corner_b_x_i,
  input  logic signed [31:0] corner_b_y_i,
  output logic               empty_o,
  input  logic               pop_i,
  output logic [2:0]         key_lod_o,
  output logic [15:0]        key_layer_o,
  output logic signed [31:0] tile_col_o,
  output logic signed [31:0] tile_row_o,
  output logic               large_shape_o,
  output logic               last_key_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [31:0]        cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  logic [15:0] base_q;
  logic [6:0] refs_q;
  logic jv, jr;
  btb_pkg::job_t job;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= btb_pkg::DefaultTileSize; refs_q <= 7'd1;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == 32'(btb_pkg::CFG_BASE_TILE_SIZE)) base_q <= cfg_data_i[15:0];
      else if (cfg_index_i == 32'(btb_pkg::CFG_MAX_REFS)) refs_q <= cfg_data_i[6:0];
    end
  end

  btb_front u_front (
    .clk_i, .rst_ni, .push_i, .full_o, .lod_level_i, .layer_id_i,
    .corner_a_x_i, .corner_a_y_i, .corner_b_x_i, .corner_b_y_i,
    .base_tile_size_i(base_q), .max_refs_i(refs_q),
    .job_valid_o(jv), .job_ready_i(jr), .job_o(job)
  );

  btb_back u_back (
    .clk_i, .rst_ni, .job_valid_i(jv), .job_ready_o(jr), .job_i(job),
    .empty_o, .pop_i, .key_lod_o, .key_layer_o, .tile_col_o, .tile_row_o,
    .large_shape_o, .last_key_o
  );
endmodule
